FILE: hw/rtl/rwpp_pkg.sv
// Package for the RIFF WAVE PCM parser: tags, format constants, error codes
// and the result word type. No dependencies.
package rwpp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [15:0] PCM_BITS = 16'd16;

    localparam logic [23:0] MAX_RATE_RESET = 24'd192000;
    localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;

    localparam int TDATA_W = 80;

    localparam logic [3:0] ERR_OK         = 4'd0;
    localparam logic [3:0] ERR_SHORT      = 4'd1;
    localparam logic [3:0] ERR_NOT_RIFF   = 4'd2;
    localparam logic [3:0] ERR_NOT_WAVE   = 4'd3;
    localparam logic [3:0] ERR_RIFF_PAST  = 4'd4;
    localparam logic [3:0] ERR_CHUNK_PAST = 4'd5;
    localparam logic [3:0] ERR_FMT_SHORT  = 4'd6;
    localparam logic [3:0] ERR_NOT_PCM    = 4'd7;
    localparam logic [3:0] ERR_BITS       = 4'd8;
    localparam logic [3:0] ERR_CHANNELS   = 4'd9;
    localparam logic [3:0] ERR_RATE       = 4'd10;
    localparam logic [3:0] ERR_ALIGN      = 4'd11;
    localparam logic [3:0] ERR_DATA_TWICE = 4'd12;
    localparam logic [3:0] ERR_NO_FMT     = 4'd13;
    localparam logic [3:0] ERR_NO_DATA    = 4'd14;

    // One result word; kind is 0 for a sample and 1 for the closing status.
    typedef struct packed {
        logic        kind;
        logic [15:0] pcm_sample;
        logic [3:0]  error_code;
        logic [32:0] error_offset;
        logic [23:0] sample_rate;
        logic [1:0]  channel_count;
    } res_t;

endpackage

FILE: hw/rtl/riff_wave_pcm_parser.sv
// Top level of the RIFF WAVE PCM16 parser: byte-wide stream in, sample and
// status words out. Depends on rwpp_pkg.

// The parser takes one file byte per cycle and sustains one byte per cycle as
// long as the output side keeps up. Every byte updates the parse state through
// short counter, compare and field logic. Samples of the data chunk leave as
// tentative words (tuser 0) on every second data byte; the byte flagged with
// tlast closes the file with one status word (tuser 1) carrying the error
// code, offset, rate and channel count, after which the next byte starts a new
// file. Results sit in a two-word output buffer; a new byte is taken when the
// buffer is empty or its one word leaves in the same cycle, so input waits
// after a byte that yields both a last sample and the status. The max_rate
// register resets to 192000 and is written through cfg_we/cfg_wdata, by the
// user only while the block is idle; the block itself does not enforce this.
module riff_wave_pcm_parser
    import rwpp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] file_byte
    input  logic               s_tlast,   // end_of_file
    output logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] pcm_sample, [19:16] error_code, [52:20] error_offset,
    // [76:53] sample_rate, [78:77] channel_count, [79] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,   // kind
    input  logic               cfg_we,
    input  logic [23:0]        cfg_wdata  // max_rate
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_CHUNK_HDR, PH_FMT, PH_DATA, PH_SKIP, PH_DONE
    } phase_t;

    logic [23:0] max_rate_reg;
    phase_t      phase_reg, phase_next;
    logic [32:0] pos_reg, pos_next;
    logic [32:0] riff_end_reg, riff_end_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [32:0] body_reg, body_next;
    logic [63:0] fmt0_reg, fmt0_next;
    logic [63:0] fmt1_reg, fmt1_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic [23:0] rate_reg, rate_next;
    logic [1:0]  chans_reg, chans_next;
    logic [2:0]  align_reg, align_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [32:0] dstart_reg, dstart_next;
    logic [3:0]  herr_reg, herr_next;
    logic [32:0] hoff_reg, hoff_next;
    logic [7:0]  low_reg, low_next;

    res_t        out0_reg, out1_reg;
    logic [1:0]  cnt_reg;

    logic        s_acc, m_acc;
    logic [32:0] np;
    logic [33:0] nxt;
    logic [33:0] data_end;
    logic        begin_ok;
    logic        do_finish, do_begin;
    logic [2:0]  k;
    logic [3:0]  fi;
    logic [32:0] at;
    logic [15:0] f_tag, f_chans, f_align, f_bits;
    logic [31:0] f_rate;
    logic        emit_sample;
    logic [3:0]  st_code;
    logic [32:0] st_off;
    res_t        smp_res, st_res;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = out0_reg.kind;
    assign m_tdata  = {1'b0, out0_reg.channel_count, out0_reg.sample_rate,
                       out0_reg.error_offset, out0_reg.error_code, out0_reg.pcm_sample};

    always_comb begin
        phase_next     = phase_reg;
        riff_end_next  = riff_end_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        body_next      = body_reg;
        fmt0_next      = fmt0_reg;
        fmt1_next      = fmt1_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        rate_next      = rate_reg;
        chans_next     = chans_reg;
        align_next     = align_reg;
        dlen_next      = dlen_reg;
        dstart_next    = dstart_reg;
        herr_next      = herr_reg;
        hoff_next      = hoff_reg;
        low_next       = low_reg;
        do_finish      = 1'b0;
        do_begin       = 1'b0;
        emit_sample    = 1'b0;

        np       = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 33'd1;
        pos_next = np;
        k        = pos_reg[2:0] - body_reg[2:0];
        fi       = pos_reg[3:0] - body_reg[3:0];
        at       = body_reg - 33'd8;

        // Byte lane insertion into the header and format words.
        unique case (phase_reg)
            PH_HEADER: begin
                if (pos_reg < 33'd4) begin
                    tag_next = tag_reg | ({24'd0, s_tdata} << {pos_reg[1:0], 3'b000});
                end else if (pos_reg < 33'd8) begin
                    len_next = len_reg | ({24'd0, s_tdata} << {pos_reg[1:0], 3'b000});
                end else if (pos_reg < 33'd12) begin
                    fmt0_next = fmt0_reg | ({56'd0, s_tdata} << {1'b0, pos_reg[1:0], 3'b000});
                end
                if (pos_reg == 33'd11) begin
                    riff_end_next = {1'b0, len_reg} + 33'd8;
                end
            end
            PH_CHUNK_HDR: begin
                if (!k[2]) begin
                    tag_next = tag_reg | ({24'd0, s_tdata} << {k[1:0], 3'b000});
                end else begin
                    len_next = len_reg | ({24'd0, s_tdata} << {k[1:0], 3'b000});
                end
            end
            PH_FMT: begin
                if (!fi[3]) begin
                    fmt0_next = fmt0_reg | ({56'd0, s_tdata} << {fi[2:0], 3'b000});
                end else begin
                    fmt1_next = fmt1_reg | ({56'd0, s_tdata} << {fi[2:0], 3'b000});
                end
            end
            default: begin
            end
        endcase

        nxt      = {1'b0, body_reg} + {2'b00, len_next} + {33'd0, len_next[0]};
        begin_ok = ({1'b0, np} + 34'd8) <= {1'b0, riff_end_next};
        data_end = {1'b0, dstart_reg} + {2'b00, dlen_reg};

        f_tag   = fmt0_next[15:0];
        f_chans = fmt0_next[31:16];
        f_rate  = fmt0_next[63:32];
        f_align = fmt1_next[47:32];
        f_bits  = fmt1_next[63:48];

        unique case (phase_reg)
            PH_HEADER: begin
                if (pos_reg == 33'd3 && tag_next != TAG_RIFF) begin
                    herr_next = ERR_NOT_RIFF;
                end
                if (pos_reg == 33'd11) begin
                    if (herr_reg == ERR_OK && fmt0_next[31:0] != TAG_WAVE) begin
                        herr_next = ERR_NOT_WAVE;
                    end
                    fmt0_next = '0;
                    if (herr_next != ERR_OK) begin
                        phase_next = PH_DONE;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
            end
            PH_CHUNK_HDR: begin
                if (k == 3'd7) begin
                    if (({1'b0, body_reg} + {2'b00, len_next}) > {1'b0, riff_end_reg}) begin
                        herr_next  = ERR_CHUNK_PAST;
                        hoff_next  = at;
                        phase_next = PH_DONE;
                    end else if (tag_next == TAG_FMT) begin
                        if (len_next < 32'd16) begin
                            herr_next  = ERR_FMT_SHORT;
                            hoff_next  = at;
                            phase_next = PH_DONE;
                        end else begin
                            fmt0_next  = '0;
                            fmt1_next  = '0;
                            phase_next = PH_FMT;
                        end
                    end else if (tag_next == TAG_DATA) begin
                        if (data_seen_reg) begin
                            herr_next  = ERR_DATA_TWICE;
                            hoff_next  = at;
                            phase_next = PH_DONE;
                        end else begin
                            data_seen_next = 1'b1;
                            dstart_next    = body_reg;
                            dlen_next      = len_next;
                            if (len_next == 32'd0) begin
                                do_finish = 1'b1;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_FMT: begin
                if (fi == 4'd15) begin
                    phase_next = PH_DONE;
                    if (f_tag != FMT_PCM) begin
                        herr_next = ERR_NOT_PCM;
                        hoff_next = body_reg;
                    end else if (f_bits != PCM_BITS) begin
                        herr_next = ERR_BITS;
                        hoff_next = body_reg + 33'd14;
                    end else if (f_chans != 16'd1 && f_chans != 16'd2) begin
                        herr_next = ERR_CHANNELS;
                        hoff_next = body_reg + 33'd2;
                    end else if (f_rate == 32'd0 || f_rate > {8'd0, max_rate_reg}) begin
                        herr_next = ERR_RATE;
                        hoff_next = body_reg + 33'd4;
                    end else if (f_align != {f_chans[14:0], 1'b0}) begin
                        herr_next = ERR_ALIGN;
                        hoff_next = body_reg + 33'd12;
                    end else begin
                        rate_next     = f_rate[23:0];
                        chans_next    = f_chans[1:0];
                        align_next    = f_align[2:0];
                        fmt_seen_next = 1'b1;
                        do_finish     = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                if ((pos_reg[0] ^ dstart_reg[0]) == 1'b0) begin
                    low_next = s_tdata;
                end else begin
                    emit_sample = 1'b1;
                end
                if ({1'b0, np} >= data_end) begin
                    do_finish = 1'b1;
                end
            end
            PH_SKIP: begin
                if ({1'b0, np} >= nxt) begin
                    do_begin = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Close the current chunk: past the RIFF end, already at the next
        // header, or still inside a pad or unread body.
        if (do_finish) begin
            if (nxt > {1'b0, riff_end_next}) begin
                phase_next = PH_DONE;
            end else if ({1'b0, np} >= nxt) begin
                do_begin = 1'b1;
            end else begin
                phase_next = PH_SKIP;
            end
        end

        if (do_begin) begin
            if (!begin_ok) begin
                phase_next = PH_DONE;
            end else begin
                body_next  = np + 33'd8;
                tag_next   = '0;
                len_next   = '0;
                phase_next = PH_CHUNK_HDR;
            end
        end

        // Closing status, judged on the state after this byte.
        st_code = ERR_OK;
        st_off  = '0;
        if (np < 33'd12) begin
            st_code = ERR_SHORT;
            st_off  = np;
        end else if (herr_next == ERR_NOT_RIFF) begin
            st_code = ERR_NOT_RIFF;
        end else if (herr_next == ERR_NOT_WAVE) begin
            st_code = ERR_NOT_WAVE;
            st_off  = 33'd8;
        end else if (riff_end_next > np) begin
            st_code = ERR_RIFF_PAST;
            st_off  = 33'd4;
        end else if (herr_next != ERR_OK) begin
            st_code = herr_next;
            st_off  = hoff_next;
        end else if (!fmt_seen_next) begin
            st_code = ERR_NO_FMT;
            st_off  = riff_end_next;
        end else if (!data_seen_next) begin
            st_code = ERR_NO_DATA;
            st_off  = riff_end_next;
        end else if (!((align_next == 3'd2 && !dlen_next[0]) ||
                       (align_next == 3'd4 && dlen_next[1:0] == 2'b00))) begin
            st_code = ERR_NO_DATA;
            st_off  = dstart_next;
        end

        smp_res            = '0;
        smp_res.pcm_sample = {s_tdata, low_reg};
        st_res               = '0;
        st_res.kind          = 1'b1;
        st_res.error_code    = st_code;
        st_res.error_offset  = st_off;
        st_res.sample_rate   = (st_code == ERR_OK) ? rate_next : 24'd0;
        st_res.channel_count = (st_code == ERR_OK) ? chans_next : 2'd0;

        if (s_tlast) begin
            phase_next     = PH_HEADER;
            pos_next       = '0;
            riff_end_next  = '0;
            tag_next       = '0;
            len_next       = '0;
            body_next      = '0;
            fmt0_next      = '0;
            fmt1_next      = '0;
            fmt_seen_next  = 1'b0;
            data_seen_next = 1'b0;
            rate_next      = '0;
            chans_next     = '0;
            align_next     = '0;
            dlen_next      = '0;
            dstart_next    = '0;
            herr_next      = ERR_OK;
            hoff_next      = '0;
            low_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rate_reg  <= MAX_RATE_RESET;
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            riff_end_reg  <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            body_reg      <= '0;
            fmt0_reg      <= '0;
            fmt1_reg      <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            rate_reg      <= '0;
            chans_reg     <= '0;
            align_reg     <= '0;
            dlen_reg      <= '0;
            dstart_reg    <= '0;
            herr_reg      <= ERR_OK;
            hoff_reg      <= '0;
            low_reg       <= '0;
            cnt_reg       <= 2'd0;
        end else begin
            if (cfg_we) begin
                max_rate_reg <= cfg_wdata;
            end
            if (s_acc) begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                riff_end_reg  <= riff_end_next;
                tag_reg       <= tag_next;
                len_reg       <= len_next;
                body_reg      <= body_next;
                fmt0_reg      <= fmt0_next;
                fmt1_reg      <= fmt1_next;
                fmt_seen_reg  <= fmt_seen_next;
                data_seen_reg <= data_seen_next;
                rate_reg      <= rate_next;
                chans_reg     <= chans_next;
                align_reg     <= align_next;
                dlen_reg      <= dlen_next;
                dstart_reg    <= dstart_next;
                herr_reg      <= herr_next;
                hoff_reg      <= hoff_next;
                low_reg       <= low_next;
                cnt_reg       <= {1'b0, emit_sample} + {1'b0, s_tlast};
            end else if (m_acc) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Output buffer payload: an accepted byte finds the buffer empty or its one word leaving.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out0_reg <= emit_sample ? smp_res : st_res;
            out1_reg <= st_res;
        end else if (m_acc) begin
            out0_reg <= out1_reg;
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("output buffer count out of range");
    a_eof_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> m_tvalid) else $error("no word after end of file");
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> (!out0_reg.kind && out1_reg.kind))
        else $error("sample and status out of order");
    a_header_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (pos_reg < 33'd12))
        else $error("header phase beyond byte 11");
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'd0))
        else $error("status word carries a sample");
`endif

endmodule
